// ----- sv/fcpg_pkg.sv -----
// Shared constants, codes and types for the filled circle point generator.
// No dependencies; compiled first.
package fcpg_pkg;

   localparam int COORD_BITS  = 10;
   localparam int RADIUS_BITS = 9;
   localparam int POINT_BITS  = 12;
   // step offsets reach radius and dip to -1; error stays within a few radii
   localparam int STEP_BITS   = RADIUS_BITS + 2;
   localparam int ERR_BITS    = RADIUS_BITS + 4;
   // width that holds center +/- offset exactly before wrap to point width
   localparam int SUM_BITS    = ((COORD_BITS > STEP_BITS) ? COORD_BITS : STEP_BITS) + 2;
   localparam int CALC_BITS   = (SUM_BITS > POINT_BITS) ? SUM_BITS : POINT_BITS;
   localparam int PTS_PER_BATCH = 8;
   localparam int PT_IDX_BITS   = 3;

   typedef enum logic {
      MODE_START   = 1'b0,
      MODE_ADVANCE = 1'b1
   } mode_type;

   // one octant step, handed from front to back
   typedef struct packed {
      logic        [COORD_BITS-1:0] cx;
      logic        [COORD_BITS-1:0] cy;
      logic signed [STEP_BITS-1:0]  dx;
      logic signed [STEP_BITS-1:0]  dy;
      logic                         done;
   } batch_type;

endpackage

// ----- sv/fcpg_if.sv -----
// Valid/ready channel interfaces for request and response beats.
// Depends on fcpg_pkg.
interface fcpg_req_if;
   import fcpg_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   mode;
   logic [COORD_BITS-1:0]  center_x;
   logic [COORD_BITS-1:0]  center_y;
   logic [RADIUS_BITS-1:0] radius;
   modport source (output valid, mode, center_x, center_y, radius, input ready);
   modport sink   (input valid, mode, center_x, center_y, radius, output ready);
endinterface

interface fcpg_rsp_if;
   import fcpg_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [POINT_BITS-1:0] point_x;
   logic signed [POINT_BITS-1:0] point_y;
   logic                         last_of_batch;
   logic                         circle_done;
   modport source (output valid, point_x, point_y, last_of_batch, circle_done, input ready);
   modport sink   (input valid, point_x, point_y, last_of_batch, circle_done, output ready);
endinterface

// ----- sv/filled_circle_point_generator_top.sv -----
// Top level of the filled circle point generator: front, queue, back.
// Depends on fcpg_pkg, fcpg_if, fcpg_front, fcpg_queue, fcpg_back.
//
//   channel  dir  beat carries                                 accepted when
//   req_ch   in   mode, center_x, center_y, radius             valid && ready
//   rsp_ch   out  point_x, point_y, last_of_batch, circle_done valid && ready
//
// A start beat loads center and radius and yields no output.
// Each advance beat runs one midpoint step in the front and yields eight
// point beats, one per cycle from the back's output register while the
// response port is ready. A two-deep queue lets the front take up to two
// more advances while the back drains; req ready drops only when that
// queue is full. An advance while idle is consumed with no output.
// Synchronous reset returns to idle.
module filled_circle_point_generator_top (
   input  logic       clock,
   input  logic       reset,
   fcpg_req_if.sink   req_ch,
   fcpg_rsp_if.source rsp_ch
);
   import fcpg_pkg::*;

   logic      push, q_full;
   logic      pop, head_valid;
   batch_type push_data, head_data;

   // front: step engine and circle state
   fcpg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   // decoupling queue
   fcpg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // back: eight-way symmetric expansion
   fcpg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

// ----- sv/fcpg_front.sv -----
// Front end: takes request beats, holds circle state, runs one midpoint step
// per advance and pushes a batch descriptor. Depends on fcpg_pkg, fcpg_if.
module fcpg_front (
   input  logic               clock,
   input  logic               reset,
   fcpg_req_if.sink           req_ch,
   input  logic               q_full,
   output logic               push,
   output fcpg_pkg::batch_type push_data
);
   import fcpg_pkg::*;

   logic                    active_ff, active_in;
   logic [COORD_BITS-1:0]   cx_ff, cx_in;
   logic [COORD_BITS-1:0]   cy_ff, cy_in;
   logic [RADIUS_BITS-1:0]  radius_ff, radius_in;
   logic [RADIUS_BITS-1:0]  ring_ff, ring_in;
   logic signed [STEP_BITS-1:0] dx_ff, dx_in;
   logic signed [STEP_BITS-1:0] dy_ff, dy_in;
   logic signed [ERR_BITS-1:0]  err_ff, err_in;

   logic                        accept;
   logic signed [STEP_BITS-1:0] dy1, dx2;
   logic signed [ERR_BITS-1:0]  err1, err2;
   logic                        ring_end, done;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      // midpoint step
      dy1  = dy_ff;
      err1 = err_ff;
      if (err_ff <= 0) begin
         dy1  = dy_ff + STEP_BITS'(1);
         err1 = err_ff + ERR_BITS'(signed'({dy1, 1'b1}));
      end
      dx2  = dx_ff;
      err2 = err1;
      if (err1 > 0) begin
         dx2  = dx_ff - STEP_BITS'(1);
         err2 = err1 - ERR_BITS'(signed'({dx2, 1'b1}));
      end
      ring_end = dx2 < dy1;
      done     = ring_end && (ring_ff >= radius_ff);

      active_in = active_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      radius_in = radius_ff;
      ring_in   = ring_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      err_in    = err_ff;
      push      = 1'b0;

      if (accept) begin
         if (mode_type'(req_ch.mode) == MODE_START) begin
            active_in = 1'b1;
            cx_in     = req_ch.center_x;
            cy_in     = req_ch.center_y;
            radius_in = req_ch.radius;
            ring_in   = '0;
            dx_in     = '0;
            dy_in     = '0;
            err_in    = '0;
         end else if (active_ff) begin
            push   = 1'b1;
            dx_in  = dx2;
            dy_in  = dy1;
            err_in = err2;
            if (done) begin
               active_in = 1'b0;
            end else if (ring_end) begin
               ring_in = ring_ff + RADIUS_BITS'(1);
               dx_in   = STEP_BITS'(ring_ff) + STEP_BITS'(1);
               dy_in   = '0;
               err_in  = '0;
            end
         end
      end

      push_data.cx   = cx_ff;
      push_data.cy   = cy_ff;
      push_data.dx   = dx_ff;
      push_data.dy   = dy_ff;
      push_data.done = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cx_ff     <= '0;
         cy_ff     <= '0;
         radius_ff <= '0;
         ring_ff   <= '0;
         dx_ff     <= '0;
         dy_ff     <= '0;
         err_ff    <= '0;
      end else begin
         active_ff <= active_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         radius_ff <= radius_in;
         ring_ff   <= ring_in;
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         err_ff    <= err_in;
      end
   end

endmodule

// ----- sv/fcpg_queue.sv -----
// Two-entry queue of batch descriptors between front and back.
// Depends on fcpg_pkg.
module fcpg_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  fcpg_pkg::batch_type  push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output fcpg_pkg::batch_type  head_data
);
   import fcpg_pkg::*;

   batch_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/fcpg_back.sv -----
// Back end: expands one batch descriptor into eight symmetric points, one
// beat per cycle unless rsp_ch stalls, through an output register. Depends on fcpg_pkg, fcpg_if.
module fcpg_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  fcpg_pkg::batch_type  head_data,
   output logic                 pop,
   fcpg_rsp_if.source           rsp_ch
);
   import fcpg_pkg::*;

   logic                     busy_ff, busy_in;
   logic [PT_IDX_BITS-1:0]   idx_ff, idx_in;
   batch_type                cur_ff;
   logic                     vld_ff, vld_in;
   logic signed [POINT_BITS-1:0] px_ff, py_ff;
   logic                     last_ff, done_ff;

   logic                     out_free, emit, last_pt;
   logic signed [CALC_BITS-1:0] cx_w, cy_w, dx_w, dy_w, xoff, yoff, sx, sy;

   assign out_free = !vld_ff || rsp_ch.ready;
   assign emit     = busy_ff && out_free;
   assign last_pt  = idx_ff == PT_IDX_BITS'(PTS_PER_BATCH - 1);
   assign pop      = head_valid && (!busy_ff || (emit && last_pt));

   always_comb begin
      cx_w = signed'(CALC_BITS'(cur_ff.cx));
      cy_w = signed'(CALC_BITS'(cur_ff.cy));
      dx_w = CALC_BITS'(cur_ff.dx);
      dy_w = CALC_BITS'(cur_ff.dy);
      case (idx_ff)
         3'd0: begin xoff =  dx_w; yoff =  dy_w; end
         3'd1: begin xoff =  dy_w; yoff =  dx_w; end
         3'd2: begin xoff = -dy_w; yoff =  dx_w; end
         3'd3: begin xoff = -dx_w; yoff =  dy_w; end
         3'd4: begin xoff = -dx_w; yoff = -dy_w; end
         3'd5: begin xoff = -dy_w; yoff = -dx_w; end
         3'd6: begin xoff =  dy_w; yoff = -dx_w; end
         default: begin xoff = dx_w; yoff = -dy_w; end
      endcase
      sx = cx_w + xoff;
      sy = cy_w + yoff;

      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (emit) begin
         idx_in = idx_ff + PT_IDX_BITS'(1);
         if (last_pt) begin
            busy_in = 1'b0;
         end
      end
      if (pop) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end

      vld_in = vld_ff;
      if (emit) begin
         vld_in = 1'b1;
      end else if (rsp_ch.ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         vld_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head_data;
      end
      if (emit) begin
         px_ff   <= sx[POINT_BITS-1:0];
         py_ff   <= sy[POINT_BITS-1:0];
         last_ff <= last_pt;
         done_ff <= cur_ff.done;
      end
   end

   assign rsp_ch.valid         = vld_ff;
   assign rsp_ch.point_x       = px_ff;
   assign rsp_ch.point_y       = py_ff;
   assign rsp_ch.last_of_batch = last_ff;
   assign rsp_ch.circle_done   = done_ff;

endmodule

// ----- test/tb_filled_circle_point_generator_top.sv -----
// Testbench for filled_circle_point_generator_top: drives start/advance beats, predicts every
// point beat with a scoreboard class, and checks the response stream in order.
// Depends on fcpg_pkg, fcpg_if and the RTL under sv/.
module tb_filled_circle_point_generator_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fcpg_pkg::*;

   // one expected point beat on the response channel
   typedef struct packed {
      logic signed [POINT_BITS-1:0] x;
      logic signed [POINT_BITS-1:0] y;
      logic                         last;
      logic                         done;
   } circle_point_type;

   // Tracks the rasterizer state and holds the point beats still owed by the block.
   class point_scoreboard;
      circle_point_type       expected_points[$];
      int                     errors;
      int                     checked;
      bit                     running;
      logic [COORD_BITS-1:0]  hold_x;
      logic [COORD_BITS-1:0]  hold_y;
      logic [RADIUS_BITS-1:0] hold_r;
      int                     ring;
      int                     dx;
      int                     dy;
      int                     err;

      function new();
         errors  = 0;
         checked = 0;
         running = 0;
         hold_x  = '0;
         hold_y  = '0;
         hold_r  = '0;
         ring    = 0;
         dx      = 0;
         dy      = 0;
         err     = 0;
      endfunction

      function void push_point(int px, int py, bit last, bit done);
         circle_point_type p;
         p.x    = POINT_BITS'(px);
         p.y    = POINT_BITS'(py);
         p.last = last;
         p.done = done;
         expected_points.push_back(p);
      endfunction

      // called once per accepted request beat
      function void note_request(mode_type mode, logic [COORD_BITS-1:0] cx,
                                 logic [COORD_BITS-1:0] cy, logic [RADIUS_BITS-1:0] r);
         int  ox;
         int  oy;
         int  px;
         int  py;
         bit  done;
         if (mode == MODE_START) begin
            hold_x  = cx;
            hold_y  = cy;
            hold_r  = r;
            ring    = 0;
            dx      = 0;
            dy      = 0;
            err     = 0;
            running = 1;
            return;
         end
         if (!running)
            return;
         ox = dx;
         oy = dy;
         px = int'(hold_x);
         py = int'(hold_y);
         // midpoint step
         if (err <= 0) begin
            dy  = dy + 1;
            err = err + 2 * dy + 1;
         end
         if (err > 0) begin
            dx  = dx - 1;
            err = err - 2 * dx + 1 - 2;
            err = err + 2 - 2;
         end
         done = 0;
         if (dx < dy) begin
            if (ring >= int'(hold_r)) begin
               done    = 1;
               running = 0;
            end else begin
               ring = ring + 1;
               dx   = ring;
               dy   = 0;
               err  = 0;
            end
         end
         // eight octant mirrors, fixed order
         push_point(px + ox, py + oy, 0, done);
         push_point(px + oy, py + ox, 0, done);
         push_point(px - oy, py + ox, 0, done);
         push_point(px - ox, py + oy, 0, done);
         push_point(px - ox, py - oy, 0, done);
         push_point(px - oy, py - ox, 0, done);
         push_point(px + oy, py - ox, 0, done);
         push_point(px + ox, py - oy, 1, done);
      endfunction

      function void check_point(circle_point_type got);
         circle_point_type want;
         checked++;
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected point beat x=%0d y=%0d last=%0b done=%0b",
                     $time, got.x, got.y, got.last, got.done);
            errors++;
            return;
         end
         want = expected_points.pop_front();
         if (got.x !== want.x) begin
            $display("%0t: point_x expected %0d got %0d", $time, want.x, got.x);
            errors++;
         end
         if (got.y !== want.y) begin
            $display("%0t: point_y expected %0d got %0d", $time, want.y, got.y);
            errors++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last_of_batch expected %0b got %0b", $time, want.last, got.last);
            errors++;
         end
         if (got.done !== want.done) begin
            $display("%0t: circle_done expected %0b got %0b", $time, want.done, got.done);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   fcpg_req_if req_ch ();
   fcpg_rsp_if rsp_ch ();

   filled_circle_point_generator_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   point_scoreboard sb = new();

   // set near the end of stimulus: both sides stop inserting bubbles
   bit quiet = 0;
   // one long response stall so the internal queue fills and req ready drops
   bit held_off = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // response monitor: sample on the rising edge, compare in order
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_point({rsp_ch.point_x, rsp_ch.point_y, rsp_ch.last_of_batch,
                         rsp_ch.circle_done});
   end

   // response ready: random stall bursts, plus one long hold-off
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_off && sb.checked >= 200) begin
            held_off = 1;
            rsp_ch.ready <= 1'b0;
            repeat (150) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   // Offer one request beat, with an optional bubble burst first; returns after the
   // accepting edge with the scoreboard updated. Valid stays high for a following beat.
   task automatic send_beat(mode_type mode, logic [COORD_BITS-1:0] cx,
                            logic [COORD_BITS-1:0] cy, logic [RADIUS_BITS-1:0] r);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.mode     <= mode;
      req_ch.center_x <= cx;
      req_ch.center_y <= cy;
      req_ch.radius   <= r;
      do
         @(posedge clock);
      while (!req_ch.ready);
      sb.note_request(mode, cx, cy, r);
   endtask

   // Start a circle, then advance it until it finishes or max_steps advances have gone in.
   // Advance beats carry random payload, which the block must ignore.
   task automatic run_circle(logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                             logic [RADIUS_BITS-1:0] r, int max_steps, output int beats);
      int steps;
      steps = 0;
      send_beat(MODE_START, cx, cy, r);
      while (sb.running && steps < max_steps) begin
         send_beat(MODE_ADVANCE, COORD_BITS'($urandom), COORD_BITS'($urandom),
                   RADIUS_BITS'($urandom));
         steps++;
      end
      beats = steps + 1;
   endtask

   // global watchdog
   initial begin
      #4_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int                     n;
      int                     rand_beats;
      int                     pick;
      int                     drain_cycles;
      logic [RADIUS_BITS-1:0] r;

      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.mode     = MODE_ADVANCE;
      req_ch.center_x = '0;
      req_ch.center_y = '0;
      req_ch.radius   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed ---
      // advance straight out of reset: idle, must be swallowed
      send_beat(MODE_ADVANCE, '1, '1, '1);
      // radius zero: a single final batch of eight center copies
      run_circle('0, '0, '0, 4, n);
      // idle again after the final batch
      send_beat(MODE_ADVANCE, '0, '0, '0);
      run_circle('1, '1, 9'd1, 50, n);
      run_circle('0, '1, 9'd2, 50, n);
      // max radius at the low corner: negative coordinates; restarted while active
      run_circle('0, '0, '1, 3, n);
      run_circle('1, '1, '1, 2, n);
      run_circle(10'd1023, 10'd0, 9'd511, 1, n);
      run_circle(10'd512, 10'd512, 9'd3, 50, n);
      run_circle(10'd5, 10'd1000, 9'd0, 4, n);

      // --- random ---
      // mostly complete small circles, some partial circles cut short by a restart,
      // some large radii that only get a few steps, and stray advances while idle
      rand_beats = 0;
      while (rand_beats < 70) begin
         if (rand_beats >= 55)
            quiet = 1;
         pick = $urandom_range(0, 9);
         if (pick == 0 && !sb.running) begin
            send_beat(MODE_ADVANCE, COORD_BITS'($urandom), COORD_BITS'($urandom),
                      RADIUS_BITS'($urandom));
         end else if (pick <= 1) begin
            run_circle(COORD_BITS'($urandom), COORD_BITS'($urandom),
                       RADIUS_BITS'($urandom_range(0, 6)), $urandom_range(0, 3), n);
            rand_beats += n;
         end else begin
            if ($urandom_range(0, 7) == 0)
               r = RADIUS_BITS'($urandom_range(0, 511));
            else
               r = RADIUS_BITS'($urandom_range(0, 5));
            run_circle(COORD_BITS'($urandom), COORD_BITS'($urandom), r,
                       (r > 5) ? $urandom_range(1, 8) : 1000, n);
            rand_beats += n;
         end
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;

      // wait for every owed point, then a short tail to catch strays
      drain_cycles = 0;
      while (sb.expected_points.size() != 0 && drain_cycles < 20000) begin
         @(posedge clock);
         drain_cycles++;
      end
      if (sb.expected_points.size() != 0) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         repeat (30) @(posedge clock);
         if (sb.errors == 0 && sb.expected_points.size() == 0)
            $display("RESULT: OK");
         else
            $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule
